// ===== sv/assert_macros.svh =====
// assertion macros included by branch_target_buffer_top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on clk, off while arst_n is low
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk, off while arst_n is low
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/btb_pkg.sv =====
// types, constants and helper functions of the branch target buffer
package btb_pkg;

	localparam int TableEntries = 1024;
	localparam int IdxW         = $clog2(TableEntries);
	localparam int PcW          = 32;

	localparam logic [PcW-1:0] PcStep = PcW'(4);

	// input kind carried in s_tuser
	localparam logic ActLookup  = 1'b0;
	localparam logic ActResolve = 1'b1;

	// register word index
	localparam logic RegCounterMode = 1'b0;

	typedef enum logic [1:0] {
		StStrongTaken    = 2'b00,
		StWeakTaken      = 2'b01,
		StWeakNotTaken   = 2'b10,
		StStrongNotTaken = 2'b11
	} pred_state_t;

	typedef logic [IdxW-1:0] tbl_idx_t;

	typedef struct packed {
		logic [PcW-1:0] tag;
		logic [PcW-1:0] target;
		pred_state_t    state;
	} entry_t;

	typedef struct packed {
		logic     en;
		tbl_idx_t idx;
		entry_t   data;
	} tbl_wr_t;

	function automatic tbl_idx_t slot_of(input logic [PcW-1:0] pc);
		return pc[IdxW+1:2];
	endfunction

	// mode 1: plain saturating counter; mode 0: weak-taken miss drops to strong not taken
	function automatic pred_state_t next_state(input pred_state_t s, input logic tk,
			input logic mode);
		pred_state_t n;
		n = s;
		case (s)
			StStrongTaken:    n = tk ? StStrongTaken : StWeakTaken;
			StWeakTaken:      n = tk ? StStrongTaken :
				(mode ? StWeakNotTaken : StStrongNotTaken);
			StWeakNotTaken:   n = tk ? StWeakTaken : StStrongNotTaken;
			StStrongNotTaken: n = tk ? StWeakNotTaken : StStrongNotTaken;
			default:          n = s;
		endcase
		return n;
	endfunction

endpackage

// ===== sv/btb_table.sv =====
// entry memory with one registered read port, one write port and a clearing sweep
module btb_table (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  btb_pkg::tbl_idx_t rd_idx,
	output btb_pkg::entry_t  rd_data,
	input  btb_pkg::tbl_wr_t wr,
	output logic             clearing
);
	import btb_pkg::*;

	entry_t   mem [TableEntries];
	tbl_idx_t clr_idx_q;
	logic     clearing_q;
	logic     we;
	tbl_idx_t wr_idx;
	entry_t   wr_data;

	// sweep writes zeros, i.e. empty entries in strongly taken state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == tbl_idx_t'(TableEntries - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_comb begin
		we      = clearing_q || wr.en;
		wr_idx  = clearing_q ? clr_idx_q : wr.idx;
		wr_data = clearing_q ? '0 : wr.data;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_idx];
		end
	end

	assign clearing = clearing_q;

endmodule

// ===== sv/btb_cfg.sv =====
// apb register file holding the counter mode
module btb_cfg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic        counter_mode
);
	import btb_pkg::*;

	logic counter_mode_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_mode_q <= 1'b0;
		end else if (wr_en && paddr[2] == RegCounterMode) begin
			counter_mode_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			RegCounterMode: prdata = {31'b0, counter_mode_q};
			default:        prdata = '0;
		endcase
	end

	assign counter_mode = counter_mode_q;

endmodule

// ===== sv/branch_target_buffer_top.sv =====
// branch target buffer top level: item control, lookup and resolve logic, result register
//
// channel  dir  handshake                     payload
// -------  ---  ----------------------------  ------------------------------------------
// s_*      in   s_tvalid / s_tready           s_tuser action, s_tdata fetch_pc, actual_next_pc
// m_*      out  m_tvalid / m_tready           m_tdata pred_pc and eight result flags
// apb      in   psel & penable & pwrite       counter_mode at byte address 0
//
// an item is read from the table in the beat cycle; compare, write back and result load
// follow once the output register can take the result; one item is in flight at a
// time, as busy_s1 holds s_tready low until the write back
// after reset a sweep clears the 1024 entries, one a cycle; s_tready stays low while
// the sweep runs, apb writes are taken throughout
// a result waiting in the output register does not block the next beat; the item
// behind it holds its read data until the output register frees
module branch_target_buffer_top (
	input  logic        clk,
	input  logic        arst_n,
	// slave stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] fetch_pc, [63:32] actual_next_pc
	input  logic        s_tuser,   // [0] action
	// master stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] pred_pc, [32] hit, [33] collision,
	                               // [34] taken, [35] prediction_correct,
	                               // [36] prediction_wrong, [37] target_fixed,
	                               // [38] allocated, [39] replaced_collision
	// config port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import btb_pkg::*;

	logic           counter_mode;
	logic           clearing;
	logic           accept;
	logic           done;
	logic           rd_en;
	tbl_idx_t       rd_idx;
	entry_t         rd_data;
	tbl_wr_t        tbl_wr;

	// item held between table read and write back
	logic           busy_s1;
	logic           action_s1;
	logic [PcW-1:0] fetch_pc_s1;
	logic [PcW-1:0] actual_s1;

	// remembered lookup for the following resolve
	logic [PcW-1:0] last_pc_q;
	logic [PcW-1:0] last_pred_q;
	logic           last_col_q;

	// output register
	logic           m_tvalid_q;
	logic [39:0]    m_tdata_q;

	// lookup and resolve results
	logic           occupied;
	logic           lk_hit;
	logic           lk_col;
	logic [PcW-1:0] lk_pred;
	logic           rs_taken;
	logic           rs_match;
	logic           rs_fix;
	logic           rs_alloc;
	entry_t         new_entry;
	logic [39:0]    result;

	btb_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.counter_mode (counter_mode)
	);

	btb_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (rd_en),
		.rd_idx   (rd_idx),
		.rd_data  (rd_data),
		.wr       (tbl_wr),
		.clearing (clearing)
	);

	// one item at a time, none during the clearing sweep
	assign s_tready = !clearing && !busy_s1;
	assign accept   = s_tvalid && s_tready;
	// write back and result load once the output register can take the beat
	assign done     = busy_s1 && (!m_tvalid_q || m_tready);

	// resolve reads the entry of the remembered pc, lookup that of fetch_pc
	assign rd_en  = accept;
	assign rd_idx = (s_tuser == ActResolve) ? slot_of(last_pc_q) : slot_of(s_tdata[31:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else if (accept) begin
			busy_s1 <= 1'b1;
		end else if (done) begin
			busy_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1   <= s_tuser;
			fetch_pc_s1 <= s_tdata[31:0];
			actual_s1   <= s_tdata[63:32];
		end
	end

	always_comb begin
		// lookup: empty entries have a zero tag
		occupied = rd_data.tag != '0;
		lk_hit   = occupied && rd_data.tag == fetch_pc_s1;
		lk_col   = occupied && rd_data.tag != fetch_pc_s1;
		lk_pred  = fetch_pc_s1 + PcStep;
		if (lk_hit && (rd_data.state == StStrongTaken || rd_data.state == StWeakTaken)) begin
			lk_pred = rd_data.target;
		end

		// resolve: a zero remembered pc matches an empty entry too
		rs_taken  = actual_s1 != (last_pc_q + PcStep);
		rs_match  = rd_data.tag == last_pc_q;
		rs_fix    = rs_match && rs_taken && rd_data.target != actual_s1;
		rs_alloc  = !rs_match && rs_taken;
		new_entry = rd_data;
		if (rs_match) begin
			if (rs_fix) begin
				new_entry.target = actual_s1;
			end
			new_entry.state = next_state(rd_data.state, rs_taken, counter_mode);
		end else if (rs_taken) begin
			// fresh entry goes in strongly taken and stays there on a taken update
			new_entry.tag    = last_pc_q;
			new_entry.target = actual_s1;
			new_entry.state  = StStrongTaken;
		end

		tbl_wr.en   = done && action_s1 == ActResolve && (rs_match || rs_taken);
		tbl_wr.idx  = slot_of(last_pc_q);
		tbl_wr.data = new_entry;

		if (action_s1 == ActLookup) begin
			result = {8'b0, lk_pred};
			result[32] = lk_hit;
			result[33] = lk_col;
		end else begin
			result = '0;
			result[34] = rs_taken;
			result[35] = rs_match && last_pred_q == actual_s1;
			result[36] = rs_match && last_pred_q != actual_s1;
			result[37] = rs_fix;
			result[38] = rs_alloc;
			result[39] = rs_alloc && last_col_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pc_q   <= '0;
			last_pred_q <= '0;
			last_col_q  <= 1'b0;
		end else if (done && action_s1 == ActLookup) begin
			last_pc_q   <= fetch_pc_s1;
			last_pred_q <= lk_pred;
			last_col_q  <= lk_col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (done) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			m_tdata_q <= result;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`include "assert_macros.svh"

	// a beat leaves the control busy and closes the input for the next cycle
	`ASSERT_NEXT(a_accept_busy, accept, busy_s1 && !s_tready,
		"accepted beat did not occupy the item stage")
	// only a resolving item writes the table outside the clearing sweep
	`ASSERT_IMPL(a_wr_resolve, tbl_wr.en, busy_s1 && action_s1 == ActResolve && !clearing,
		"table write without a resolving item")
	// a lookup result never reports both hit and collision
	`ASSERT_IMPL(a_hit_col, m_tvalid_q, !(m_tdata_q[32] && m_tdata_q[33]),
		"result shows hit and collision together")

endmodule
